### rtl/hsv_to_rgb_converter_unit_assert.svh
// assertion macros for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// checked only outside reset
`define H2R_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("h2r assertion failed");

// checked in every cycle, reset included
`define H2R_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("h2r assertion failed");

`endif

### rtl/h2r_pkg.sv
// shared constants and widths for the hsv to rgb converter
`timescale 1ns / 1ps
package h2r_pkg;

   localparam int FRAC_BITS = 12;
   localparam int ONE       = 1 << FRAC_BITS;

   localparam int HUE_W   = 16;
   localparam int FIELD_W = 13;
   localparam int CHAN_W  = 8;

   localparam int HUE_FULL   = 5760;
   localparam int HUE_SECT   = 960;
   localparam int SECT_SHIFT = 6;
   localparam int HUE_OFFSET = 6 * HUE_FULL;
   localparam int HUE_BIAS   = HUE_OFFSET - (1 << (HUE_W - 1));

   localparam int U_W      = 17;
   localparam int IDX_W    = 7;
   localparam int REM_W    = 10;
   localparam int SECTOR_W = 3;

   localparam int RECIP15       = 17477;
   localparam int RECIP15_W     = 15;
   localparam int RECIP15_SHIFT = 18;
   localparam int RECIP6        = 43;
   localparam int RECIP6_W      = 6;
   localparam int RECIP6_SHIFT  = 8;
   localparam int DIV6_W        = 4;

   localparam int X_W         = FRAC_BITS + REM_W;
   localparam int PROD_W      = FIELD_W + X_W;
   localparam int SCALE_W     = PROD_W + CHAN_W;
   localparam int SCALE_SHIFT = 2 * FRAC_BITS + SECT_SHIFT;
   localparam int Y_W         = 12;

   localparam int NUM_STAGES = 8;

   localparam logic [SECTOR_W-1:0] SECT_RED_YELLOW    = 3'd0;
   localparam logic [SECTOR_W-1:0] SECT_YELLOW_GREEN  = 3'd1;
   localparam logic [SECTOR_W-1:0] SECT_GREEN_CYAN    = 3'd2;
   localparam logic [SECTOR_W-1:0] SECT_CYAN_BLUE     = 3'd3;
   localparam logic [SECTOR_W-1:0] SECT_BLUE_MAGENTA  = 3'd4;

endpackage

### rtl/h2r_hue_split.sv
// hue wrap into sector and remainder, saturation and value clamp (three stages)
`timescale 1ns / 1ps
module h2r_hue_split (
   input  logic                                clock,
   input  logic [2:0]                          stage_en,
   input  logic signed [h2r_pkg::HUE_W-1:0]    hue,
   input  logic [h2r_pkg::FIELD_W-1:0]         saturation,
   input  logic [h2r_pkg::FIELD_W-1:0]         brightness,
   output logic [h2r_pkg::SECTOR_W-1:0]        sector,
   output logic [h2r_pkg::REM_W-1:0]           rem,
   output logic [h2r_pkg::FIELD_W-1:0]         sat_clamp,
   output logic [h2r_pkg::FIELD_W-1:0]         val_clamp
);

   localparam int IDX_PROD_W = h2r_pkg::U_W - h2r_pkg::SECT_SHIFT + h2r_pkg::RECIP15_W;
   localparam int D6_PROD_W  = h2r_pkg::IDX_W + h2r_pkg::RECIP6_W;

   logic [h2r_pkg::U_W-1:0]      u_in, u_ff, u2_ff;
   logic [h2r_pkg::FIELD_W-1:0]  s_in, s1_ff, s2_ff, s3_ff;
   logic [h2r_pkg::FIELD_W-1:0]  v_in, v1_ff, v2_ff, v3_ff;
   logic [IDX_PROD_W-1:0]        idx_prod;
   logic [h2r_pkg::IDX_W-1:0]    idx_in, idx_ff;
   logic [h2r_pkg::U_W-1:0]      rem_full;
   logic [D6_PROD_W-1:0]         d6_prod;
   logic [h2r_pkg::DIV6_W-1:0]   d6;
   logic [h2r_pkg::IDX_W-1:0]    sector_full;
   logic [h2r_pkg::SECTOR_W-1:0] sector_in, sector_ff;
   logic [h2r_pkg::REM_W-1:0]    rem_in, rem_ff;

   // stage 1: bias hue to a positive value, clamp s and v to one
   assign u_in = h2r_pkg::U_W'({1'b0, ~hue[h2r_pkg::HUE_W-1], hue[h2r_pkg::HUE_W-2:0]})
               + h2r_pkg::U_W'(h2r_pkg::HUE_BIAS);
   assign s_in = (saturation > h2r_pkg::FIELD_W'(h2r_pkg::ONE)) ?
                 h2r_pkg::FIELD_W'(h2r_pkg::ONE) : saturation;
   assign v_in = (brightness > h2r_pkg::FIELD_W'(h2r_pkg::ONE)) ?
                 h2r_pkg::FIELD_W'(h2r_pkg::ONE) : brightness;

   // stage 2: sixty degree count, u / 960 as (u >> 6) / 15
   assign idx_prod = IDX_PROD_W'(u_ff[h2r_pkg::U_W-1:h2r_pkg::SECT_SHIFT])
                   * IDX_PROD_W'(h2r_pkg::RECIP15);
   assign idx_in   = idx_prod[h2r_pkg::RECIP15_SHIFT +: h2r_pkg::IDX_W];

   // stage 3: remainder within the sector, count mod 6
   assign rem_full    = u2_ff - h2r_pkg::U_W'(idx_ff) * h2r_pkg::U_W'(h2r_pkg::HUE_SECT);
   assign rem_in      = rem_full[h2r_pkg::REM_W-1:0];
   assign d6_prod     = D6_PROD_W'(idx_ff) * D6_PROD_W'(h2r_pkg::RECIP6);
   assign d6          = d6_prod[h2r_pkg::RECIP6_SHIFT +: h2r_pkg::DIV6_W];
   assign sector_full = idx_ff - h2r_pkg::IDX_W'(d6) * h2r_pkg::IDX_W'(6);
   assign sector_in   = sector_full[h2r_pkg::SECTOR_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         u_ff  <= u_in;
         s1_ff <= s_in;
         v1_ff <= v_in;
      end
      if (stage_en[1]) begin
         idx_ff <= idx_in;
         u2_ff  <= u_ff;
         s2_ff  <= s1_ff;
         v2_ff  <= v1_ff;
      end
      if (stage_en[2]) begin
         sector_ff <= sector_in;
         rem_ff    <= rem_in;
         s3_ff     <= s2_ff;
         v3_ff     <= v2_ff;
      end
   end

   assign sector    = sector_ff;
   assign rem       = rem_ff;
   assign sat_clamp = s3_ff;
   assign val_clamp = v3_ff;

endmodule

### rtl/h2r_chan_mix.sv
// p, q and t terms and sector routing to the three channels (two stages)
`timescale 1ns / 1ps
module h2r_chan_mix (
   input  logic                          clock,
   input  logic [1:0]                    stage_en,
   input  logic [h2r_pkg::SECTOR_W-1:0]  sector,
   input  logic [h2r_pkg::REM_W-1:0]     rem,
   input  logic [h2r_pkg::FIELD_W-1:0]   sat_clamp,
   input  logic [h2r_pkg::FIELD_W-1:0]   val_clamp,
   output logic [h2r_pkg::FIELD_W-1:0]   val_out,
   output logic [h2r_pkg::X_W-1:0]       x_red,
   output logic [h2r_pkg::X_W-1:0]       x_green,
   output logic [h2r_pkg::X_W-1:0]       x_blue
);

   localparam logic [h2r_pkg::X_W-1:0] X_FULL = h2r_pkg::X_W'(h2r_pkg::ONE * h2r_pkg::HUE_SECT);

   logic [h2r_pkg::X_W-1:0]      xp_in, xp_ff, xq_in, xq_ff, xt_in, xt_ff;
   logic [h2r_pkg::X_W-1:0]      sr, st;
   logic [h2r_pkg::REM_W-1:0]    rem_inv;
   logic [h2r_pkg::SECTOR_W-1:0] sector_ff;
   logic [h2r_pkg::FIELD_W-1:0]  v4_ff, v5_ff;
   logic [h2r_pkg::X_W-1:0]      xr_in, xg_in, xb_in, xr_ff, xg_ff, xb_ff;

   // stage 4: weights of p, q, t in units of 1 / (one * 960)
   assign rem_inv = h2r_pkg::REM_W'(h2r_pkg::HUE_SECT) - rem;
   assign sr      = h2r_pkg::X_W'(sat_clamp) * h2r_pkg::X_W'(rem);
   assign st      = h2r_pkg::X_W'(sat_clamp) * h2r_pkg::X_W'(rem_inv);
   assign xp_in   = h2r_pkg::X_W'(h2r_pkg::FIELD_W'(h2r_pkg::ONE) - sat_clamp)
                  * h2r_pkg::X_W'(h2r_pkg::HUE_SECT);
   assign xq_in   = X_FULL - sr;
   assign xt_in   = X_FULL - st;

   // stage 5: sector routing
   always_comb begin
      unique case (sector_ff)
         h2r_pkg::SECT_RED_YELLOW: begin
            xr_in = X_FULL; xg_in = xt_ff;  xb_in = xp_ff;
         end
         h2r_pkg::SECT_YELLOW_GREEN: begin
            xr_in = xq_ff;  xg_in = X_FULL; xb_in = xp_ff;
         end
         h2r_pkg::SECT_GREEN_CYAN: begin
            xr_in = xp_ff;  xg_in = X_FULL; xb_in = xt_ff;
         end
         h2r_pkg::SECT_CYAN_BLUE: begin
            xr_in = xp_ff;  xg_in = xq_ff;  xb_in = X_FULL;
         end
         h2r_pkg::SECT_BLUE_MAGENTA: begin
            xr_in = xt_ff;  xg_in = xp_ff;  xb_in = X_FULL;
         end
         default: begin
            xr_in = X_FULL; xg_in = xp_ff;  xb_in = xq_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         xp_ff     <= xp_in;
         xq_ff     <= xq_in;
         xt_ff     <= xt_in;
         sector_ff <= sector;
         v4_ff     <= val_clamp;
      end
      if (stage_en[1]) begin
         xr_ff <= xr_in;
         xg_ff <= xg_in;
         xb_ff <= xb_in;
         v5_ff <= v4_ff;
      end
   end

   assign val_out = v5_ff;
   assign x_red   = xr_ff;
   assign x_green = xg_ff;
   assign x_blue  = xb_ff;

endmodule

### rtl/h2r_chan_scale.sv
// one channel: v times weight, times 255, exact floor division (three stages)
`timescale 1ns / 1ps
module h2r_chan_scale (
   input  logic                          clock,
   input  logic [2:0]                    stage_en,
   input  logic [h2r_pkg::FIELD_W-1:0]   val,
   input  logic [h2r_pkg::X_W-1:0]       weight,
   output logic [h2r_pkg::CHAN_W-1:0]    chan
);

   localparam int Q_PROD_W = h2r_pkg::Y_W + h2r_pkg::RECIP15_W;

   logic [h2r_pkg::PROD_W-1:0]  prod_in, prod_ff;
   logic [h2r_pkg::SCALE_W-1:0] scaled;
   logic [h2r_pkg::Y_W-1:0]     y_in, y_ff;
   logic [Q_PROD_W-1:0]         q_prod;
   logic [h2r_pkg::CHAN_W-1:0]  chan_in, chan_ff;

   assign prod_in = h2r_pkg::PROD_W'(val) * h2r_pkg::PROD_W'(weight);

   // times 255, then drop 2^(2 * frac + 6) of the 15 * 2^(2 * frac + 6) divisor
   assign scaled = (h2r_pkg::SCALE_W'(prod_ff) << h2r_pkg::CHAN_W) - h2r_pkg::SCALE_W'(prod_ff);
   assign y_in   = scaled[h2r_pkg::SCALE_SHIFT +: h2r_pkg::Y_W];

   // remaining divide by 15, exact over the whole range of y
   assign q_prod  = Q_PROD_W'(y_ff) * Q_PROD_W'(h2r_pkg::RECIP15);
   assign chan_in = q_prod[h2r_pkg::RECIP15_SHIFT +: h2r_pkg::CHAN_W];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[1]) begin
         y_ff <= y_in;
      end
      if (stage_en[2]) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

### rtl/hsv_to_rgb_converter_unit.sv
// hsv to rgb converter top level
// an accepted item passes every stage register in order to reach the rsp side
// throughput: one item per cycle while rsp_stall is low; an eight stage pipeline with a valid bit per stage
// a stall fills empty stages first and backs up to req_stall only when all are full
// reset clears the stage valid bits; data registers are not reset
`timescale 1ns / 1ps
module hsv_to_rgb_converter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [h2r_pkg::HUE_W-1:0]   req_hue,
   input  logic [h2r_pkg::FIELD_W-1:0]        req_saturation,
   input  logic [h2r_pkg::FIELD_W-1:0]        req_brightness,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [h2r_pkg::CHAN_W-1:0]         rsp_red,
   output logic [h2r_pkg::CHAN_W-1:0]         rsp_green,
   output logic [h2r_pkg::CHAN_W-1:0]         rsp_blue
);

   logic [h2r_pkg::NUM_STAGES-1:0] valid_ff, valid_in;
   logic [h2r_pkg::NUM_STAGES:0]   stage_en;

   logic [h2r_pkg::SECTOR_W-1:0] sector;
   logic [h2r_pkg::REM_W-1:0]    rem;
   logic [h2r_pkg::FIELD_W-1:0]  sat_clamp, val_clamp, val_mix;
   logic [h2r_pkg::X_W-1:0]      x_red, x_green, x_blue;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      stage_en[h2r_pkg::NUM_STAGES] = !rsp_stall;
      for (int k = h2r_pkg::NUM_STAGES - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign valid_in = {valid_ff[h2r_pkg::NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < h2r_pkg::NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[h2r_pkg::NUM_STAGES-1];

   h2r_hue_split u_hue_split (
      .clock      (clock),
      .stage_en   (stage_en[2:0]),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .sector     (sector),
      .rem        (rem),
      .sat_clamp  (sat_clamp),
      .val_clamp  (val_clamp)
   );

   h2r_chan_mix u_chan_mix (
      .clock     (clock),
      .stage_en  (stage_en[4:3]),
      .sector    (sector),
      .rem       (rem),
      .sat_clamp (sat_clamp),
      .val_clamp (val_clamp),
      .val_out   (val_mix),
      .x_red     (x_red),
      .x_green   (x_green),
      .x_blue    (x_blue)
   );

   h2r_chan_scale u_scale_red (
      .clock    (clock),
      .stage_en (stage_en[7:5]),
      .val      (val_mix),
      .weight   (x_red),
      .chan     (rsp_red)
   );

   h2r_chan_scale u_scale_green (
      .clock    (clock),
      .stage_en (stage_en[7:5]),
      .val      (val_mix),
      .weight   (x_green),
      .chan     (rsp_green)
   );

   h2r_chan_scale u_scale_blue (
      .clock    (clock),
      .stage_en (stage_en[7:5]),
      .val      (val_mix),
      .weight   (x_blue),
      .chan     (rsp_blue)
   );

endmodule

### rtl/h2r_checker.sv
// port level checker for the hsv to rgb converter, bound to the top level
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_unit_assert.svh"
module h2r_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [h2r_pkg::FIELD_W-1:0]        req_saturation,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [h2r_pkg::CHAN_W-1:0]         rsp_red,
   input logic [h2r_pkg::CHAN_W-1:0]         rsp_green,
   input logic [h2r_pkg::CHAN_W-1:0]         rsp_blue
);

   logic                             gray_acc;
   logic                             run_clear;
   logic                             gray_out;
   logic [3*h2r_pkg::CHAN_W-1:0]     rsp_rgb;

   assign gray_acc  = req_valid && !req_stall && !reset && req_saturation == '0;
   assign run_clear = !rsp_stall && !reset;
   assign gray_out  = rsp_valid && rsp_red == rsp_green && rsp_green == rsp_blue;
   assign rsp_rgb   = {rsp_red, rsp_green, rsp_blue};

   // pipeline empty and open after reset
   `H2R_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall)

   // input backs up only behind a valid result that rsp_stall holds
   `H2R_ASSERT(a_stall_backs_up, clock, reset, req_stall |-> rsp_valid && rsp_stall)

   `H2R_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rgb))

   // a gray item followed by a free run arrives on the rsp side with equal channels
   `H2R_ASSERT(a_gray_latency, clock, reset, gray_acc ##1 run_clear[*7] |=> gray_out)

endmodule

bind hsv_to_rgb_converter_unit h2r_checker u_h2r_checker (.*);
